// File: hdl/matmul_pkg.sv
// matmul_pkg: shared widths, request and register codes, payload and control structs
// used by every module of the matrix multiply core; depends on nothing

package matmul_pkg;

   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH     = 16;
   localparam int PROD_WIDTH     = 2 * ELEM_WIDTH;
   localparam int SUM_WIDTH      = 36;
   localparam int DIM_WIDTH      = 4;
   localparam int IDX_WIDTH      = 3;
   localparam int SIZE_WIDTH     = 2 * DIM_WIDTH;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_START  = 2'd2;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   localparam logic [DIM_WIDTH-1:0] DIM_RESET = DIM_WIDTH'(8);

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [ELEM_WIDTH-1:0] element_value;
   } matmul_req_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] product_value;
      logic [IDX_WIDTH-1:0]        out_row;
      logic [IDX_WIDTH-1:0]        out_col;
      logic                        last;
   } matmul_rsp_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0] rows_a;
      logic [DIM_WIDTH-1:0] inner_dim;
      logic [DIM_WIDTH-1:0] cols_b;
   } matmul_dims_type;

   typedef struct packed {
      logic                 load_a;
      logic                 load_b;
      logic                 start;
      logic                 issue;
      logic                 first_k;
      logic                 last_k;
      logic                 push;
      logic                 row_end;
      logic [IDX_WIDTH-1:0] row;
      logic [IDX_WIDTH-1:0] col;
      logic                 last;
   } matmul_cmd_type;

   typedef struct packed {
      logic acc_ready;
      logic out_free;
   } matmul_status_type;

endpackage

// File: hdl/matmul_csr.sv
// matmul_csr: size registers behind the apb-style port, with clamping of the sizes in use
// depends on matmul_pkg

module matmul_csr
   import matmul_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output matmul_dims_type           dims
);

   logic [DIM_WIDTH-1:0] rows_a_ff, rows_a_in;
   logic [DIM_WIDTH-1:0] inner_dim_ff, inner_dim_in;
   logic [DIM_WIDTH-1:0] cols_b_ff, cols_b_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v);
      logic [DIM_WIDTH-1:0] r;
      priority if (v == '0) begin
         r = DIM_WIDTH'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_WIDTH'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ROWS_A:    rows_a_in    = csr_pwdata[DIM_WIDTH-1:0];
            REG_INNER_DIM: inner_dim_in = csr_pwdata[DIM_WIDTH-1:0];
            REG_COLS_B:    cols_b_in    = csr_pwdata[DIM_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROWS_A:    csr_prdata = CSR_DATA_WIDTH'(rows_a_ff);
         REG_INNER_DIM: csr_prdata = CSR_DATA_WIDTH'(inner_dim_ff);
         REG_COLS_B:    csr_prdata = CSR_DATA_WIDTH'(cols_b_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign dims.rows_a    = clamp_dim(rows_a_ff);
   assign dims.inner_dim = clamp_dim(inner_dim_ff);
   assign dims.cols_b    = clamp_dim(cols_b_ff);

endmodule

// File: hdl/matmul_ctrl.sv
// matmul_ctrl: state machine that sequences loads and the row, column and inner loops
// depends on matmul_pkg; drives the datapath by command and reads its status

module matmul_ctrl
   import matmul_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_kind,
   output logic              req_stall,
   input  matmul_dims_type   dims,
   input  matmul_status_type status,
   output matmul_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [DIM_WIDTH-1:0] i_ff, i_in;
   logic [DIM_WIDTH-1:0] j_ff, j_in;
   logic [DIM_WIDTH-1:0] k_ff, k_in;
   logic                 accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  REQ_LOAD_A: cmd.load_a = 1'b1;
                  REQ_LOAD_B: cmd.load_b = 1'b1;
                  REQ_START: begin
                     cmd.start = 1'b1;
                     i_in      = '0;
                     j_in      = '0;
                     k_in      = '0;
                     state_in  = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue   = 1'b1;
            cmd.first_k = (k_ff == '0);
            cmd.last_k  = (k_ff == dims.inner_dim - DIM_WIDTH'(1));
            if (cmd.last_k) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_WIDTH'(1);
            end
         end
         ST_DRAIN: begin
            if (status.acc_ready && status.out_free) begin
               cmd.push    = 1'b1;
               cmd.row     = i_ff[IDX_WIDTH-1:0];
               cmd.col     = j_ff[IDX_WIDTH-1:0];
               cmd.row_end = (j_ff == dims.cols_b - DIM_WIDTH'(1));
               cmd.last    = cmd.row_end && (i_ff == dims.rows_a - DIM_WIDTH'(1));
               priority if (cmd.last) begin
                  state_in = ST_IDLE;
               end else if (cmd.row_end) begin
                  j_in     = '0;
                  i_in     = i_ff + DIM_WIDTH'(1);
                  state_in = ST_ISSUE;
               end else begin
                  j_in     = j_ff + DIM_WIDTH'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

// File: hdl/matmul_dp.sv
// matmul_dp: element stores, load positions, address walk, multiply-accumulate and output register
// depends on matmul_pkg; acts on commands from matmul_ctrl

module matmul_dp
   import matmul_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  matmul_cmd_type               cmd,
   input  matmul_dims_type              dims,
   input  logic signed [ELEM_WIDTH-1:0] load_value,
   input  logic                         rsp_stall,
   output matmul_status_type            status,
   output logic                         rsp_valid,
   output matmul_rsp_type               rsp_data
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_RAW = $clog2(DEPTH + MAX_DIM + 1);
   localparam int POS_W   = (POS_RAW > SIZE_WIDTH) ? POS_RAW : SIZE_WIDTH;

   logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

   logic [SIZE_WIDTH-1:0] a_size, b_size;
   logic [POS_W-1:0]      a_size_w, b_size_w;
   logic [POS_W-1:0]      a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [POS_W-1:0]      a_pos, a_pos_inc, b_pos, b_pos_inc;
   logic [POS_W-1:0]      n_w, p_w;
   logic [POS_W-1:0]      a_base_ff, a_base_in, a_addr_ff, a_addr_in;
   logic [POS_W-1:0]      b_col_ff, b_col_in, b_addr_ff, b_addr_in;

   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic                         s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                         s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [SUM_WIDTH-1:0]         prod_ext, acc_ff, acc_in;
   logic                         acc_ready_ff, acc_ready_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   matmul_rsp_type               rsp_data_ff;

   // load positions, wrapping at the matrix size
   assign a_size    = SIZE_WIDTH'(dims.rows_a) * SIZE_WIDTH'(dims.inner_dim);
   assign b_size    = SIZE_WIDTH'(dims.inner_dim) * SIZE_WIDTH'(dims.cols_b);
   assign a_size_w  = POS_W'(a_size);
   assign b_size_w  = POS_W'(b_size);
   assign a_pos     = (a_cnt_ff >= a_size_w) ? '0 : a_cnt_ff;
   assign b_pos     = (b_cnt_ff >= b_size_w) ? '0 : b_cnt_ff;
   assign a_pos_inc = a_pos + POS_W'(1);
   assign b_pos_inc = b_pos + POS_W'(1);

   always_comb begin
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      priority if (cmd.start) begin
         a_cnt_in = '0;
         b_cnt_in = '0;
      end else if (cmd.load_a) begin
         a_cnt_in = (a_pos_inc >= a_size_w) ? '0 : a_pos_inc;
      end else if (cmd.load_b) begin
         b_cnt_in = (b_pos_inc >= b_size_w) ? '0 : b_pos_inc;
      end
   end

   // address walk: a along a row, b down a column
   assign n_w = POS_W'(dims.inner_dim);
   assign p_w = POS_W'(dims.cols_b);

   always_comb begin
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_col_in  = b_col_ff;
      b_addr_in = b_addr_ff;
      priority if (cmd.start) begin
         a_base_in = '0;
         a_addr_in = '0;
         b_col_in  = '0;
         b_addr_in = '0;
      end else if (cmd.issue) begin
         a_addr_in = a_addr_ff + POS_W'(1);
         b_addr_in = b_addr_ff + p_w;
      end else if (cmd.push) begin
         if (cmd.row_end) begin
            a_base_in = a_base_ff + n_w;
            a_addr_in = a_base_ff + n_w;
            b_col_in  = '0;
            b_addr_in = '0;
         end else begin
            a_addr_in = a_base_ff;
            b_col_in  = b_col_ff + POS_W'(1);
            b_addr_in = b_col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
      end else begin
         a_cnt_ff <= a_cnt_in;
         b_cnt_ff <= b_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_col_ff  <= b_col_in;
      b_addr_ff <= b_addr_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         a_mem[a_pos[ADDR_W-1:0]] <= load_value;
      end
      if (cmd.issue) begin
         a_rd_ff <= a_mem[a_addr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b) begin
         b_mem[b_pos[ADDR_W-1:0]] <= load_value;
      end
      if (cmd.issue) begin
         b_rd_ff <= b_mem[b_addr_ff[ADDR_W-1:0]];
      end
   end

   // multiply and accumulate
   assign prod_ext     = SUM_WIDTH'(prod_ff);
   assign acc_in       = s2_first_ff ? prod_ext : acc_ff + prod_ext;
   assign acc_ready_in = (s2_valid_ff && s2_last_ff) ? 1'b1 :
                         (cmd.push ? 1'b0 : acc_ready_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ready_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         acc_ready_ff <= acc_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first_k;
      s1_last_ff  <= cmd.last_k;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= a_rd_ff * b_rd_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // output register
   assign status.acc_ready = acc_ready_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in     = cmd.push || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff.product_value <= acc_ff;
         rsp_data_ff.out_row       <= cmd.row;
         rsp_data_ff.out_col       <= cmd.col;
         rsp_data_ff.last          <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/matrix_multiply_core.sv
// matrix_multiply_core: top level of the matrix multiply block, c = a x b in fixed point
// depends on matmul_pkg, matmul_csr, matmul_ctrl and matmul_dp
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  load a element, load b element, start
//   rsp_        out        rsp_valid/rsp_stall  one element of c with row, column, last
//   csr_        in/out     psel/penable/pready  rows_a, inner_dim, cols_b at 0x0, 0x4, 0x8
//
// load items are taken while idle and loads follow back to back
// a start item emits rows_a * cols_b items, with one multiply-accumulate per cycle while
// an item's inner loop issues (three pipeline stages of store read, multiply, add)
// new items are stalled while a start is in progress; a stalled result holds the unit
// synchronous active-high reset clears sizes to 8 and both load positions to zero

module matrix_multiply_core
   import matmul_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  matmul_req_type            req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output matmul_rsp_type            rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   matmul_dims_type   dims;
   matmul_cmd_type    cmd;
   matmul_status_type status;

   matmul_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   matmul_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .dims      (dims),
      .status    (status),
      .cmd       (cmd)
   );

   matmul_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dims       (dims),
      .load_value (req_data.element_value),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hdl/matmul_checker.sv
// matmul_checker: port-level assertions for matrix_multiply_core, bound to the top level
// depends on matmul_pkg and matrix_multiply_core

module matmul_checker
   import matmul_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input matmul_req_type req_data,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input matmul_rsp_type rsp_data
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // input is released only as the last element of a product goes out
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid && rsp_data.last)
      else $error("input released without last result item");

   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type != REQ_START |=> !req_stall)
      else $error("stall after a load item");

   a_start_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == REQ_START |=> req_stall)
      else $error("no stall after a start item");

endmodule

bind matrix_multiply_core matmul_checker u_checker (.*);

// File: tb/tb_matrix_multiply_core.sv
// tb_matrix_multiply_core: self-checking bench for the matrix multiply core, loads a and b
// and checks every element of c against an in-bench fixed-point predictor
// depends on matmul_pkg and matrix_multiply_core

module tb_matrix_multiply_core;
   timeunit 1ns;
   timeprecision 1ps;

   import matmul_pkg::*;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int STORE_DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF;
   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 2 * (MAX_DIM_DEF + 4);
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   matmul_req_type            req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   matmul_rsp_type            rsp_data;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   matrix_multiply_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [ELEM_WIDTH-1:0] a_mem [STORE_DEPTH];
   logic signed [ELEM_WIDTH-1:0] b_mem [STORE_DEPTH];
   logic [6:0]                   a_slot = '0;
   logic [6:0]                   b_slot = '0;
   logic [DIM_WIDTH-1:0]         cfg_rows = DIM_RESET;
   logic [DIM_WIDTH-1:0]         cfg_inner = DIM_RESET;
   logic [DIM_WIDTH-1:0]         cfg_cols = DIM_RESET;
   matmul_rsp_type               product_queue [$];

   // stimulus planning state
   matmul_req_type item_queue [$];
   logic [6:0]     plan_a = '0;
   logic [6:0]     plan_b = '0;
   logic           a_filled [STORE_DEPTH];
   logic           b_filled [STORE_DEPTH];
   int             queued_items = 0;

   int  mismatch_count = 0;
   int  checked_count = 0;
   int  load_count = 0;
   int  start_count = 0;
   int  ignored_count = 0;
   int  cfg_writes = 0;
   int  cycle_count = 0;
   logic item_taken = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   logic hold_armed = 1'b0;
   int  hold_left = 0;
   int  seg_left = 0;
   int  stall_pct = 0;

   function automatic int dim_eff(input logic [DIM_WIDTH-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(r);
   endfunction

   function automatic logic [6:0] wrap_slot(input logic [6:0] p, input int size);
      return (int'(p) >= size) ? 7'd0 : p;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic predict_item(input matmul_req_type it);
      int m, n, p, i, j, k;
      longint acc;
      logic [6:0] s;
      matmul_rsp_type r;
      m = dim_eff(cfg_rows);
      n = dim_eff(cfg_inner);
      p = dim_eff(cfg_cols);
      case (it.req_type)
         REQ_LOAD_A: begin
            s = wrap_slot(a_slot, m * n);
            a_mem[s] = it.element_value;
            a_slot = wrap_slot(s + 7'd1, m * n);
            load_count++;
         end
         REQ_LOAD_B: begin
            s = wrap_slot(b_slot, n * p);
            b_mem[s] = it.element_value;
            b_slot = wrap_slot(s + 7'd1, n * p);
            load_count++;
         end
         REQ_START: begin
            for (i = 0; i < m; i++) begin
               for (j = 0; j < p; j++) begin
                  acc = 0;
                  for (k = 0; k < n; k++)
                     acc += longint'(a_mem[i * n + k]) * longint'(b_mem[k * p + j]);
                  r.product_value = acc[SUM_WIDTH-1:0];
                  r.out_row = IDX_WIDTH'(i);
                  r.out_col = IDX_WIDTH'(j);
                  r.last = (i == m - 1) && (j == p - 1);
                  product_queue.push_back(r);
               end
            end
            a_slot = '0;
            b_slot = '0;
            start_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
   endtask

   // input acceptance and result checking
   always @(posedge clock) begin
      matmul_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (product_queue.size() == 0) begin
               note_mismatch($sformatf("unexpected item value %0d row %0d col %0d last %0b",
                  rsp_data.product_value, rsp_data.out_row, rsp_data.out_col, rsp_data.last));
            end else begin
               want = product_queue.pop_front();
               checked_count++;
               if (rsp_data.product_value !== want.product_value ||
                   rsp_data.out_row !== want.out_row || rsp_data.out_col !== want.out_col ||
                   rsp_data.last !== want.last) begin
                  note_mismatch($sformatf(
                     "exp value %0d row %0d col %0d last %0b, got %0d row %0d col %0d last %0b",
                     want.product_value, want.out_row, want.out_col, want.last,
                     rsp_data.product_value, rsp_data.out_row, rsp_data.out_col,
                     rsp_data.last));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_item(req_data);
            item_taken = 1'b1;
         end
      end
   end

   // sender: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !item_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= item_queue.pop_front();
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
      item_taken = 1'b0;
   end

   // receiver: stall pattern in segments, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed && rsp_valid) begin
         hold_armed = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 80);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 60;
            endcase
         end
         seg_left--;
         rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
   end

   function automatic logic signed [ELEM_WIDTH-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return ELEM_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic start_ready();
      int mn, np, s;
      mn = dim_eff(cfg_rows) * dim_eff(cfg_inner);
      np = dim_eff(cfg_inner) * dim_eff(cfg_cols);
      for (s = 0; s < mn; s++) if (!a_filled[s]) return 1'b0;
      for (s = 0; s < np; s++) if (!b_filled[s]) return 1'b0;
      return 1'b1;
   endfunction

   // queues an item and tracks which store entries have been written
   task automatic queue_item(input logic [1:0] kind, input logic signed [ELEM_WIDTH-1:0] value);
      matmul_req_type it;
      int mn, np;
      it.req_type = kind;
      it.element_value = value;
      item_queue.push_back(it);
      mn = dim_eff(cfg_rows) * dim_eff(cfg_inner);
      np = dim_eff(cfg_inner) * dim_eff(cfg_cols);
      if (kind == REQ_LOAD_A) begin
         plan_a = wrap_slot(plan_a, mn);
         a_filled[plan_a] = 1'b1;
         plan_a = wrap_slot(plan_a + 7'd1, mn);
      end else if (kind == REQ_LOAD_B) begin
         plan_b = wrap_slot(plan_b, np);
         b_filled[plan_b] = 1'b1;
         plan_b = wrap_slot(plan_b + 7'd1, np);
      end else if (kind == REQ_START) begin
         plan_a = '0;
         plan_b = '0;
      end
      if (kind != REQ_UNUSED) queued_items++;
   endtask

   // mostly full loads of a and b then start, sometimes a short noisy run
   task automatic queue_sequence();
      int na, nb;
      logic [1:0] kind;
      if ($urandom_range(0, 3) != 0) begin
         na = dim_eff(cfg_rows) * dim_eff(cfg_inner);
         nb = dim_eff(cfg_inner) * dim_eff(cfg_cols);
         while (na + nb > 0) begin
            if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
               queue_item(REQ_LOAD_A, rand_elem());
               na--;
            end else begin
               queue_item(REQ_LOAD_B, rand_elem());
               nb--;
            end
         end
         queue_item(REQ_START, rand_elem());
      end else begin
         repeat ($urandom_range(1, 6)) begin
            kind = 2'($urandom_range(0, 3));
            if (kind == REQ_START && !start_ready()) kind = REQ_UNUSED;
            queue_item(kind, rand_elem());
         end
         if (start_ready() && $urandom_range(0, 1) == 1) queue_item(REQ_START, rand_elem());
      end
   endtask

   task automatic wait_drained();
      while (item_queue.size() != 0 || req_valid || product_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic write, input logic [1:0] index,
                               input logic [DIM_WIDTH-1:0] value,
                               output logic [CSR_DATA_WIDTH-1:0] rdata);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = $urandom;
      word[DIM_WIDTH-1:0] = value;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= CSR_ADDR_WIDTH'({index, 2'b00});
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_register(input logic [1:0] index, input logic [DIM_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] rdata;
      csr_transfer(1'b1, index, value, rdata);
      case (index)
         REG_ROWS_A:    cfg_rows = value;
         REG_INNER_DIM: cfg_inner = value;
         default:       cfg_cols = value;
      endcase
      cfg_writes++;
      csr_transfer(1'b0, index, '0, rdata);
      if (rdata[DIM_WIDTH-1:0] !== value)
         note_mismatch($sformatf("register %0d read %0d, exp %0d", index,
            rdata[DIM_WIDTH-1:0], value));
   endtask

   task automatic set_sizes(input logic [DIM_WIDTH-1:0] rows, input logic [DIM_WIDTH-1:0] inner,
                            input logic [DIM_WIDTH-1:0] cols);
      set_register(REG_ROWS_A, rows);
      set_register(REG_INNER_DIM, inner);
      set_register(REG_COLS_B, cols);
   endtask

   function automatic logic [DIM_WIDTH-1:0] rand_dim();
      if ($urandom_range(0, 4) == 0) return DIM_WIDTH'($urandom_range(0, 15));
      return DIM_WIDTH'($urandom_range(1, 4));
   endfunction

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("matrix_multiply_core verification failed");
      $finish;
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] rdata;
      int s, idx;
      for (s = 0; s < STORE_DEPTH; s++) begin
         a_filled[s] = 1'b0;
         b_filled[s] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the size registers
      for (idx = 0; idx < 3; idx++) begin
         csr_transfer(1'b0, 2'(idx), '0, rdata);
         if (rdata[DIM_WIDTH-1:0] !== DIM_RESET)
            note_mismatch($sformatf("register %0d after reset read %0d", idx,
               rdata[DIM_WIDTH-1:0]));
      end

      // directed: extremes, ignored type, start without loads, load wrap
      set_sizes(4'd2, 4'd2, 4'd2);
      queue_item(REQ_LOAD_A, 16'sh8000);
      queue_item(REQ_LOAD_A, 16'sh8000);
      queue_item(REQ_LOAD_A, 16'sh7fff);
      queue_item(REQ_LOAD_A, -16'sd1);
      queue_item(REQ_LOAD_B, 16'sh8000);
      queue_item(REQ_LOAD_B, 16'sh7fff);
      queue_item(REQ_LOAD_B, 16'sh8000);
      queue_item(REQ_LOAD_B, 16'sd0);
      queue_item(REQ_START, 16'sd0);
      queue_item(REQ_UNUSED, 16'sh5a5a);
      queue_item(REQ_START, 16'shffff);
      for (idx = 1; idx <= 5; idx++) queue_item(REQ_LOAD_A, 16'(idx));
      queue_item(REQ_LOAD_B, 16'sh7fff);
      queue_item(REQ_START, 16'sh1234);
      wait_drained();

      // full size with largest sums, result side held off while items keep coming
      queued_items = 0;
      set_sizes(4'd8, 4'd8, 4'd8);
      hold_armed = 1'b1;
      for (idx = 0; idx < STORE_DEPTH; idx++) queue_item(REQ_LOAD_A, 16'sh8000);
      for (idx = 0; idx < STORE_DEPTH; idx++)
         queue_item(REQ_LOAD_B, (idx % 2 == 0) ? 16'sh8000 : 16'sh7fff);
      queue_item(REQ_START, rand_elem());
      repeat (10) queue_item(REQ_LOAD_A, rand_elem());
      queue_item(REQ_UNUSED, rand_elem());
      wait_drained();

      // out-of-range codes and smallest sizes
      set_sizes(4'd0, 4'd15, 4'd0);
      repeat (2) queue_sequence();
      wait_drained();
      set_sizes(4'd15, 4'd0, 4'd15);
      repeat (2) queue_sequence();
      wait_drained();
      set_sizes(4'd1, 4'd1, 4'd1);
      repeat (3) queue_sequence();
      wait_drained();

      while (queued_items < RANDOM_ITEMS) begin
         set_sizes(rand_dim(), rand_dim(), rand_dim());
         repeat ($urandom_range(2, 4)) queue_sequence();
         wait_drained();
      end

      $display("covered %0d loads, %0d starts, %0d ignored items, %0d result items checked",
         load_count, start_count, ignored_count, checked_count);
      $display("%0d size register writes, 1x1x1 through 8x8x8 plus zero and oversize codes",
         cfg_writes);
      if (mismatch_count == 0) begin
         $display("matrix_multiply_core verification clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("matrix_multiply_core verification failed");
      end
      $finish;
   end

endmodule

// File: matrix_multiply_core.f
hdl/matmul_pkg.sv
hdl/matmul_csr.sv
hdl/matmul_ctrl.sv
hdl/matmul_dp.sv
hdl/matrix_multiply_core.sv
hdl/matmul_checker.sv
tb/tb_matrix_multiply_core.sv
